// ===== hdl/cps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types, constants and helpers for the charlieplexed PWM LED scanner.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int NUM_LEDS     = 24;
    localparam int NUM_PINS     = 6;
    localparam int OUTPUT_COUNT = 9;

    localparam int LED_AW   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int LEVEL_W  = 4;
    localparam int PHASE_W  = 3;
    localparam int BASE_W   = 4;
    localparam int IDX_W    = 5;
    localparam int VAL_W    = 8;
    localparam int PIN_W    = 6;
    localparam int PIN_DIV  = NUM_PINS - 1;
    localparam int SUM_W    = IDX_W + 1;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(8);
    localparam logic [BASE_W-1:0]  BASE_RST  = BASE_W'(15);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RAW   = 2'd1,
        OP_CONF  = 2'd2,
        OP_CLEAR = 2'd3
    } cps_op_t;

    typedef struct packed {
        cps_op_t           opcode;
        logic [IDX_W-1:0]  led_index;
        logic [VAL_W-1:0]  value;
    } cps_in_t;

    typedef struct packed {
        logic [PIN_W-1:0]  pin_drive_enable;
        logic [PIN_W-1:0]  pin_high;
        logic [IDX_W-1:0]  scanned_led;
        logic              led_lit;
    } cps_out_t;

    // Access to the brightness store: write, clear-all and read controls
    typedef struct packed {
        logic               we;
        logic [LED_AW-1:0]  waddr;
        logic [LEVEL_W-1:0] wdata;
        logic               clear;
        logic               re;
        logic [LED_AW-1:0]  raddr;
    } cps_mem_cmd_t;

    // Tick context that travels alongside the store read
    typedef struct packed {
        logic [LED_AW-1:0]  led;
        logic [PHASE_W-1:0] phase;
    } cps_tick_t;

    // floor(value * 8 / 255) without a divider: x/255 == (x + 1 + (x >> 8)) >> 8
    function automatic logic [LEVEL_W-1:0] scale_conf(input logic [VAL_W-1:0] v);
        logic [VAL_W+3:0] x;
        logic [VAL_W+3:0] t;
        begin
            x = {1'b0, v, 3'b000};
            t = x + (VAL_W+4)'(1) + (x >> 8);
            scale_conf = t[VAL_W+3:8];
        end
    endfunction

endpackage : cps_pkg
`default_nettype wire

// ===== hdl/cps_bright_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cps_bright_mem
// Brightness store: one synchronous RAM with registered read, plus a valid
// bit per entry so that reset and clear-all reach every entry at once.
// ----------------------------------------------------------------------------
module cps_bright_mem
    import cps_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cps_mem_cmd_t       cmd,
    output logic [LEVEL_W-1:0]      rd_level
);

    logic [LEVEL_W-1:0]  mem [NUM_LEDS];
    logic [NUM_LEDS-1:0] valid_reg;
    logic [LEVEL_W-1:0]  rd_data_reg;
    logic                rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
        if (cmd.re)
        begin
            rd_data_reg <= mem[cmd.raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                valid_reg <= '0;
            end
            else if (cmd.we)
            begin
                valid_reg[cmd.waddr] <= 1'b1;
            end
            if (cmd.re)
            begin
                rd_hit_reg <= valid_reg[cmd.raddr];
            end
        end
    end

    // unwritten entries read as zero
    assign rd_level = rd_hit_reg ? rd_data_reg : '0;

endmodule : cps_bright_mem
`default_nettype wire

// ===== hdl/cps_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cps_out_stage
// PWM compare and pin decode for the scanned LED, into the output register.
// ----------------------------------------------------------------------------
module cps_out_stage
    import cps_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s1_valid,
    input  wire cps_tick_t          s1_tick,
    input  wire logic [LEVEL_W-1:0] level,
    output logic                    s1_adv,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cps_out_t                out_data
);

    logic                out_valid_reg;
    cps_out_t            out_data_reg;
    cps_out_t            res;
    logic [IDX_W-1:0]    led_w;
    logic [IDX_W-1:0]    anode;
    logic [IDX_W-1:0]    k;
    logic [IDX_W-1:0]    cathode;
    logic                pair_ok;
    logic                on;

    always_comb
    begin
        led_w = IDX_W'(s1_tick.led);
        // split the index into anode and remainder by comparing against
        // multiples of the pin group size
        anode = '0;
        k     = led_w;
        for (int j = 1; j <= (NUM_LEDS - 1) / PIN_DIV; j++)
        begin
            if (led_w >= IDX_W'(j * PIN_DIV))
            begin
                anode = IDX_W'(j);
                k     = led_w - IDX_W'(j * PIN_DIV);
            end
        end
        cathode = (k < anode) ? k : k + IDX_W'(1);
        pair_ok = (anode < IDX_W'(NUM_PINS)) && (cathode < IDX_W'(NUM_PINS));
        on      = (level > {1'b0, s1_tick.phase}) && pair_ok;

        res.scanned_led      = led_w;
        res.led_lit          = on;
        res.pin_drive_enable = '0;
        res.pin_high         = '0;
        if (on)
        begin
            res.pin_drive_enable = (PIN_W'(1) << anode) | (PIN_W'(1) << cathode);
            res.pin_high         = PIN_W'(1) << anode;
        end
    end

    assign s1_adv = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule : cps_out_stage
`default_nettype wire

// ===== hdl/charlieplex_pwm_led_scanner.sv =====
`default_nettype none
// A scan tick's store read and tick context register at its transfer, and its
// result enters the output register once that register is free; writes and
// clear are registered.
// Throughput: one item per cycle while the output is not stalled; one store read per tick.
// Reset clears the store's valid bits (all levels read zero), the LED index,
// the PWM phase and the pipeline; the column base resets to 15.
// ----------------------------------------------------------------------------
// charlieplex_pwm_led_scanner
// Decodes items, steps the scan index and PWM phase, drives the brightness
// store and hands tick context to the output stage.
// ----------------------------------------------------------------------------
module charlieplex_pwm_led_scanner
    import cps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [BASE_W-1:0] cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cps_in_t           in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cps_out_t               out_data
);

    logic [BASE_W-1:0]  base_reg;
    logic [LED_AW-1:0]  scan_reg;
    logic [LED_AW-1:0]  scan_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic               s1_valid_reg;
    cps_tick_t          s1_tick_reg;
    logic               s1_adv;
    logic               xfer;
    logic               tick;
    cps_mem_cmd_t       cmd;
    logic [SUM_W-1:0]   conf_addr;
    logic [LEVEL_W-1:0] level;

    assign in_ready = !s1_valid_reg || s1_adv;
    assign xfer     = in_valid && in_ready;
    assign tick     = xfer && (in_data.opcode == OP_TICK);

    assign conf_addr = SUM_W'(base_reg) + SUM_W'(in_data.led_index);

    always_comb
    begin
        cmd       = '0;
        cmd.re    = tick;
        cmd.raddr = scan_reg;
        if (xfer)
        begin
            case (in_data.opcode)
                OP_RAW:
                begin
                    cmd.we    = in_data.led_index < IDX_W'(NUM_LEDS);
                    cmd.waddr = in_data.led_index[LED_AW-1:0];
                    cmd.wdata = (in_data.value > VAL_W'(LEVEL_MAX)) ?
                                LEVEL_MAX : in_data.value[LEVEL_W-1:0];
                end
                OP_CONF:
                begin
                    cmd.we    = (in_data.led_index < IDX_W'(OUTPUT_COUNT)) &&
                                (conf_addr < SUM_W'(NUM_LEDS));
                    cmd.waddr = conf_addr[LED_AW-1:0];
                    cmd.wdata = scale_conf(in_data.value);
                end
                OP_CLEAR:
                begin
                    cmd.clear = 1'b1;
                end
                default:
                begin
                    cmd.clear = 1'b0;
                end
            endcase
        end
    end

    // advance the LED index; step the phase on wrap
    always_comb
    begin
        scan_next  = scan_reg + LED_AW'(1);
        phase_next = phase_reg;
        if (scan_reg == LED_AW'(NUM_LEDS - 1))
        begin
            scan_next  = '0;
            phase_next = phase_reg + PHASE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= BASE_RST;
            scan_reg     <= '0;
            phase_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (tick)
            begin
                scan_reg  <= scan_next;
                phase_reg <= phase_next;
            end
            if (in_ready)
            begin
                s1_valid_reg <= tick;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            s1_tick_reg.led   <= scan_reg;
            s1_tick_reg.phase <= phase_reg;
        end
    end

    cps_bright_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_level (level)
    );

    cps_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid_reg),
        .s1_tick   (s1_tick_reg),
        .level     (level),
        .s1_adv    (s1_adv),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule : charlieplex_pwm_led_scanner
`default_nettype wire

// ===== hdl/cps_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cps_checker
// Port-level checks for the LED scanner, bound to the top level.
// ----------------------------------------------------------------------------
module cps_checker
    import cps_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_ready,
    input  wire logic     out_valid,
    input  wire logic     out_ready,
    input  wire cps_out_t out_data
);

    // a stalled result transfer holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    a_led_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.scanned_led < IDX_W'(NUM_LEDS))
        else $error("scanned LED out of range");

    a_unlit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.led_lit |->
            out_data.pin_drive_enable == '0 && out_data.pin_high == '0)
        else $error("pins driven for unlit LED");

    a_lit_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.led_lit |->
            $countones(out_data.pin_drive_enable) == 2 &&
            $onehot(out_data.pin_high) &&
            (out_data.pin_high & ~out_data.pin_drive_enable) == '0)
        else $error("lit LED without one anode and one cathode");

    // the input side frees up once a stalled result drains
    a_ready_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !in_valid |=> in_ready)
        else $error("input stalled with an empty pipeline");

endmodule : cps_checker

bind charlieplex_pwm_led_scanner cps_checker u_cps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

// ===== tb/charlieplex_pwm_led_scanner_test.sv =====
// ----------------------------------------------------------------------------
// charlieplex_pwm_led_scanner_test
// Self-checking bench for the charlieplexed PWM LED scanner. Items go in from
// a queue and results are compared with a scanner model. Both sides idle at
// random, and the receiver stalls once for a long time. The column base is
// rewritten between phases.
// ----------------------------------------------------------------------------
module charlieplex_pwm_led_scanner_test;
    import cps_pkg::*;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [BASE_W-1:0] cfg_wdata = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    cps_in_t           in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    cps_out_t          out_data;

    // scanner model state
    logic [LEVEL_W-1:0] level_store [NUM_LEDS];
    int                 scan_pos;
    logic [PHASE_W-1:0] pwm_step;
    logic [BASE_W-1:0]  column_base;

    cps_in_t  pending_items [$];
    cps_out_t expected_scans [$];
    int       fail_count  = 0;
    bit       calm_phase  = 1'b0;
    bit       stall_armed = 1'b0;
    bit       stall_used  = 1'b0;
    int       hold_left   = 0;

    charlieplex_pwm_led_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Update the model for one item; a scan tick also queues its pin pattern.
    task automatic advance_scanner(input cps_in_t it);
        cps_out_t scan;
        int       entry;
        int       anode;
        int       k;
        int       cathode;
        case (it.opcode)
            OP_RAW:
                if (it.led_index < NUM_LEDS)
                    level_store[it.led_index] = (it.value > 8) ? LEVEL_MAX : it.value[3:0];
            OP_CONF:
                if (it.led_index < OUTPUT_COUNT)
                begin
                    entry = int'(column_base) + int'(it.led_index);
                    if (entry < NUM_LEDS)
                        level_store[entry] = LEVEL_W'((int'(it.value) * 8) / 255);
                end
            OP_CLEAR:
                foreach (level_store[i])
                    level_store[i] = '0;
            default:
            begin
                entry = (scan_pos >= NUM_LEDS) ? 0 : scan_pos;
                scan = '0;
                scan.scanned_led = IDX_W'(entry);
                if (level_store[entry] > pwm_step)
                begin
                    anode   = entry / (NUM_PINS - 1);
                    k       = entry % (NUM_PINS - 1);
                    cathode = (k < anode) ? k : k + 1;
                    if (anode < NUM_PINS && cathode < NUM_PINS)
                    begin
                        scan.pin_drive_enable = PIN_W'((1 << anode) | (1 << cathode));
                        scan.pin_high         = PIN_W'(1 << anode);
                        scan.led_lit          = 1'b1;
                    end
                end
                expected_scans.push_back(scan);
                entry++;
                if (entry >= NUM_LEDS)
                begin
                    entry = 0;
                    pwm_step++;
                end
                scan_pos = entry;
            end
        endcase
    endtask

    function automatic cps_in_t make_item(cps_op_t op, int idx, int val);
        cps_in_t it;
        it.opcode    = op;
        it.led_index = IDX_W'(idx);
        it.value     = VAL_W'(val);
        return it;
    endfunction

    function automatic cps_in_t random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return make_item(OP_TICK, $urandom_range(31), $urandom_range(255));
        if (pick < 75)
            return make_item(OP_RAW,
                ($urandom_range(9) == 0) ? $urandom_range(31, 24) : $urandom_range(23),
                ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(8));
        if (pick < 97)
            return make_item(OP_CONF,
                ($urandom_range(7) == 0) ? $urandom_range(31, 9) : $urandom_range(8),
                $urandom_range(255));
        return make_item(OP_CLEAR, $urandom_range(31), $urandom_range(255));
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_items.size() != 0 && (calm_phase || $urandom_range(99) >= 37))
            begin
                in_valid <= 1'b1;
                in_data  <= pending_items.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off while the sender keeps offering items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (stall_armed && !stall_used)
            begin
                stall_used = 1'b1;
                hold_left  = 300;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm_phase || ($urandom_range(99) >= 37);
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        cps_out_t want;
        if (!rst_n)
        begin
            foreach (level_store[i])
                level_store[i] = '0;
            scan_pos    = 0;
            pwm_step    = '0;
            column_base = BASE_RST;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_scans.size() == 0)
                begin
                    $error("unexpected result transfer: led %0d", out_data.scanned_led);
                    fail_count++;
                end
                else
                begin
                    want = expected_scans.pop_front();
                    if (out_data.pin_drive_enable !== want.pin_drive_enable)
                    begin
                        $error("pin_drive_enable: expected %b, got %b",
                               want.pin_drive_enable, out_data.pin_drive_enable);
                        fail_count++;
                    end
                    if (out_data.pin_high !== want.pin_high)
                    begin
                        $error("pin_high: expected %b, got %b",
                               want.pin_high, out_data.pin_high);
                        fail_count++;
                    end
                    if (out_data.scanned_led !== want.scanned_led)
                    begin
                        $error("scanned_led: expected %0d, got %0d",
                               want.scanned_led, out_data.scanned_led);
                        fail_count++;
                    end
                    if (out_data.led_lit !== want.led_lit)
                    begin
                        $error("led_lit: expected %0d, got %0d",
                               want.led_lit, out_data.led_lit);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
                column_base = cfg_wdata;
            if (in_valid && in_ready)
                advance_scanner(in_data);
        end
    end

    // Wait until every item is in and every result is out, then let the pipe settle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_scans.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_column_base(input int base);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= BASE_W'(base);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        repeat (count)
            pending_items.push_back(random_item());
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: saturation, ignored indices, confidence scaling, lit and unlit ticks
        pending_items.push_back(make_item(OP_RAW, 0, 8));
        pending_items.push_back(make_item(OP_RAW, 1, 255));
        pending_items.push_back(make_item(OP_RAW, 2, 9));
        pending_items.push_back(make_item(OP_RAW, 24, 5));
        pending_items.push_back(make_item(OP_RAW, 31, 255));
        pending_items.push_back(make_item(OP_CONF, 0, 255));
        pending_items.push_back(make_item(OP_CONF, 8, 128));
        pending_items.push_back(make_item(OP_CONF, 9, 255));
        pending_items.push_back(make_item(OP_CONF, 31, 255));
        pending_items.push_back(make_item(OP_CONF, 1, 32));
        pending_items.push_back(make_item(OP_CONF, 2, 31));
        pending_items.push_back(make_item(OP_RAW, 3, 1));
        repeat (6)
            pending_items.push_back(make_item(OP_TICK, 0, 0));
        pending_items.push_back(make_item(OP_CLEAR, 31, 255));
        repeat (3)
            pending_items.push_back(make_item(OP_TICK, 31, 255));
        wait_drained();

        write_column_base(0);
        queue_random(250);
        wait_drained();

        // run without idling, then with idling again
        write_column_base(15);
        calm_phase = 1'b1;
        queue_random(130);
        wait (pending_items.size() == 0);
        calm_phase = 1'b0;
        queue_random(120);
        wait_drained();

        // hold off the receiver so the block backs up into its input
        write_column_base(7);
        stall_armed = 1'b1;
        queue_random(250);
        wait_drained();

        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("charlieplex_pwm_led_scanner regression: pass");
        else
            $display("charlieplex_pwm_led_scanner regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("charlieplex_pwm_led_scanner regression: fail");
        $finish;
    end

endmodule
